@@ rtl/cga_pkg.sv @@
// Shared types, constants and helper functions of the CGA register and memory unit.
package cga_pkg;

  // Request codes carried in the input tuser.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Port offsets inside the sixteen-port window.
  localparam logic [3:0] IO_LAST_CRTC = 4'd7;
  localparam logic [3:0] IO_MODE      = 4'd8;
  localparam logic [3:0] IO_COLOR     = 4'd9;
  localparam logic [3:0] IO_STATUS    = 4'd10;
  localparam int unsigned IO_SPAN     = 15;

  localparam logic [1:0] BE_HIGH = 2'd2;
  localparam logic [1:0] BE_BOTH = 2'd3;

  // Fixed field and state widths.
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned IOB_W    = 16;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned VOFF_W   = 16;
  localparam int unsigned SEL_W    = 5;
  localparam int unsigned FRAME_W  = 17;
  localparam int unsigned BLINK_W  = 22;
  localparam int unsigned LINE_W   = 10;

  // Parameter defaults.
  localparam int unsigned DEF_VRAM_BYTES       = 16384;
  localparam int unsigned DEF_CRTC_COUNT       = 18;
  localparam int unsigned DEF_FRAME_TICKS      = 79545;
  localparam int unsigned DEF_RETRACE_START    = 74200;
  localparam int unsigned DEF_BLINK_HALF_TICKS = 2386364;
  localparam int unsigned DEF_LINE_TICKS       = 228;

  localparam int unsigned DISPLAY_TICKS = 180;

  localparam logic [ADDR_W-1:0] RST_VRAM_BASE = 20'hB8000;
  localparam logic [IOB_W-1:0]  RST_IO_BASE   = 16'h03D0;
  localparam logic [7:0]        RST_MODE      = 8'h29;
  localparam logic [7:0]        STAT_RETRACE  = 8'h08;
  localparam logic [7:0]        STAT_DISPLAY  = 8'h01;

  localparam logic CFG_VRAM_BASE = 1'b0;
  localparam logic CFG_IO_BASE   = 1'b1;

  // What the back end has to do with one queued item.
  typedef enum logic [3:0] {
    K_NONE  = 4'd0,   // tick-free no-op or miss: nothing claimed
    K_CLAIM = 4'd1,   // claimed, no effect, reads zero
    K_VRD   = 4'd2,
    K_VWR   = 4'd3,
    K_IDX   = 4'd4,
    K_CRD   = 4'd5,
    K_CWR   = 4'd6,
    K_MODE  = 4'd7,
    K_COLOR = 4'd8,
    K_STAT  = 4'd9,
    K_TICK  = 4'd10
  } item_kind_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [VOFF_W-1:0]   off;
    logic                last;    // offset is the final byte of the window
    logic [7:0]          wbyte;
    logic [DATA_W-1:0]   data;
    logic [1:0]          be;
    logic                word;
  } item_t;

  function automatic logic [7:0] crtc_mask(input logic [SEL_W-1:0] i);
    logic [7:0] m;
    case (i)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd13, 5'd15: m = 8'hFF;
      5'd4, 5'd6, 5'd7, 5'd10:              m = 8'h7F;
      5'd5, 5'd9, 5'd11:                    m = 8'h1F;
      5'd8:                                 m = 8'hF3;
      5'd12, 5'd14:                         m = 8'h3F;
      default:                              m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] crtc_init(input logic [SEL_W-1:0] i);
    logic [7:0] v;
    case (i)
      5'd0:    v = 8'h71;
      5'd1:    v = 8'h50;
      5'd2:    v = 8'h5A;
      5'd3:    v = 8'h0A;
      5'd4:    v = 8'h1F;
      5'd5:    v = 8'h06;
      5'd6:    v = 8'h19;
      5'd7:    v = 8'h1C;
      5'd8:    v = 8'h02;
      5'd9:    v = 8'h07;
      5'd10:   v = 8'h06;
      5'd11:   v = 8'h07;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Places a byte on the lane a byte read asked for.
  function automatic logic [DATA_W-1:0] on_lane(input logic [1:0] be, input logic [7:0] b);
    return (be == BE_HIGH) ? {b, 8'h00} : {8'h00, b};
  endfunction

endpackage

@@ rtl/cga_video_register_and_memory_unit.sv @@
// Top level of the CGA video register and memory unit.
//
// Requests arrive as beats on the s_axis channel: a bus read, a bus write or
// one video clock tick. Each accepted beat produces exactly one result beat on
// m_axis carrying the claim flag, read data and the mode, color, blink and
// dirty state as they stand after that request.
// The front end decodes a beat against the video memory window and the
// sixteen-port register window and places it in a two-entry queue; the back
// end executes it against the video memory banks and the CRTC register file.
// A register access or a tick is held in the queue and then written to the
// result register; a video memory read is held in the queue, read through the
// registered read port of the memory banks, and written to the result register
// from the read state. Sustained rate is one beat per cycle while m_axis_tready
// stays high, except that a video memory read holds the back end in the read
// state, so the next beat waits in the queue until the read result is written.
// After reset the back end zeroes video memory one even/odd byte pair per
// cycle; s_axis_tready stays low until that pass finishes. Configuration
// writes on the cfg channel are always taken. When the receiver holds
// m_axis_tready low the result stays in the output register, the queue fills,
// and s_axis_tready falls once it is full.
module cga_video_register_and_memory_unit #(
  parameter int unsigned VRAM_BYTES       = cga_pkg::DEF_VRAM_BYTES,
  parameter int unsigned CRTC_COUNT       = cga_pkg::DEF_CRTC_COUNT,
  parameter int unsigned FRAME_TICKS      = cga_pkg::DEF_FRAME_TICKS,
  parameter int unsigned RETRACE_START    = cga_pkg::DEF_RETRACE_START,
  parameter int unsigned BLINK_HALF_TICKS = cga_pkg::DEF_BLINK_HALF_TICKS,
  parameter int unsigned LINE_TICKS       = cga_pkg::DEF_LINE_TICKS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // address[19:0], write_data[35:20], lane_enable[37:36], word_access[38], zero[39]
  input  logic [39:0]                s_axis_tdata,
  // opcode[1:0], is_io[2]
  input  logic [2:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // read_data[15:0], blink_out[16], dirty_out[17], mode_out[25:18],
  // color_out[33:26], zero[39:34]
  output logic [39:0]                m_axis_tdata,
  // claimed[0]
  output logic                       m_axis_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [cga_pkg::ADDR_W-1:0] cfg_data
);
  import cga_pkg::*;

  logic  clearing;
  logic  q_valid;
  logic  q_pop;
  item_t q_head;

  cga_front #(.VRAM_BYTES(VRAM_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .clearing(clearing),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  cga_back #(
    .VRAM_BYTES(VRAM_BYTES), .CRTC_COUNT(CRTC_COUNT),
    .FRAME_TICKS(FRAME_TICKS), .RETRACE_START(RETRACE_START),
    .BLINK_HALF_TICKS(BLINK_HALF_TICKS), .LINE_TICKS(LINE_TICKS)
  ) u_back (
    .clk(clk), .rst(rst),
    .clearing(clearing),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

endmodule

@@ rtl/cga_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cga_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/cga_front.sv @@
// Front end: configuration registers, input decode and a two-entry item queue.
module cga_front #(
  parameter int unsigned VRAM_BYTES = cga_pkg::DEF_VRAM_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,
  input  logic [2:0]                   s_axis_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [cga_pkg::ADDR_W-1:0]   cfg_data,
  input  logic                         clearing,
  output logic                         q_valid,
  output cga_pkg::item_t               q_head,
  input  logic                         q_pop
);
  import cga_pkg::*;

  logic [ADDR_W-1:0] vram_base;
  logic [IOB_W-1:0]  io_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vram_base <= RST_VRAM_BASE;
      io_base   <= RST_IO_BASE;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_VRAM_BASE) begin
        vram_base <= cfg_data;
      end else begin
        io_base <= cfg_data[IOB_W-1:0];
      end
    end
  end

  logic [1:0]        opcode;
  logic              is_io;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] wdata;
  logic [1:0]        be;
  logic              word;
  logic              is_wr;
  logic              vram_hit;
  logic              io_hit;
  logic [ADDR_W-1:0] vdiff;
  logic [3:0]        ioff;
  item_t             item;

  assign opcode  = s_axis_tuser[1:0];
  assign is_io   = s_axis_tuser[2];
  assign address = s_axis_tdata[19:0];
  assign wdata   = s_axis_tdata[35:20];
  assign be      = s_axis_tdata[37:36];
  assign word    = s_axis_tdata[38];
  assign is_wr   = (opcode == OP_WRITE);

  assign vdiff    = address - vram_base;
  assign ioff     = 4'(address - ADDR_W'(io_base));
  assign vram_hit = !is_io && (address >= vram_base) &&
                    ({1'b0, address} < ({1'b0, vram_base} + 21'(VRAM_BYTES)));
  assign io_hit   = is_io && (address >= ADDR_W'(io_base)) &&
                    ({1'b0, address} <= (21'(io_base) + 21'(IO_SPAN)));

  always_comb begin
    item.off   = VOFF_W'(vdiff);
    item.last  = (17'(item.off) + 17'd1) >= 17'(VRAM_BYTES);
    item.wbyte = (be == BE_HIGH) ? wdata[15:8] : wdata[7:0];
    item.data  = wdata;
    item.be    = be;
    item.word  = word;
    item.kind  = K_NONE;
    if (opcode == OP_TICK) begin
      item.kind = K_TICK;
    end else if (opcode == OP_READ || opcode == OP_WRITE) begin
      if (vram_hit) begin
        item.kind = is_wr ? K_VWR : K_VRD;
      end else if (io_hit) begin
        if (ioff <= IO_LAST_CRTC) begin
          if (ioff[0]) item.kind = is_wr ? K_CWR : K_CRD;
          else         item.kind = is_wr ? K_IDX : K_CLAIM;
        end else begin
          case (ioff)
            IO_MODE:   item.kind = is_wr ? K_MODE : K_CLAIM;
            IO_COLOR:  item.kind = is_wr ? K_COLOR : K_CLAIM;
            IO_STATUS: item.kind = is_wr ? K_CLAIM : K_STAT;
            default:   item.kind = K_CLAIM;
          endcase
        end
      end
    end
  end

  // Two-entry queue between decode and execution.
  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign s_axis_tready = (count != 2'd2) && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_head        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)  wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ rtl/cga_back.sv @@
// Back end: video memory, CRTC file, mode/color registers, timing counters, result register.
module cga_back #(
  parameter int unsigned VRAM_BYTES       = cga_pkg::DEF_VRAM_BYTES,
  parameter int unsigned CRTC_COUNT       = cga_pkg::DEF_CRTC_COUNT,
  parameter int unsigned FRAME_TICKS      = cga_pkg::DEF_FRAME_TICKS,
  parameter int unsigned RETRACE_START    = cga_pkg::DEF_RETRACE_START,
  parameter int unsigned BLINK_HALF_TICKS = cga_pkg::DEF_BLINK_HALF_TICKS,
  parameter int unsigned LINE_TICKS       = cga_pkg::DEF_LINE_TICKS
) (
  input  logic            clk,
  input  logic            rst,
  output logic            clearing,
  input  logic            q_valid,
  input  cga_pkg::item_t  q_head,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [39:0]     m_axis_tdata,
  output logic            m_axis_tuser
);
  import cga_pkg::*;

  localparam int unsigned EVEN_DEPTH = (VRAM_BYTES + 1) / 2;
  localparam int unsigned ODD_DEPTH  = VRAM_BYTES / 2;
  localparam int unsigned EA_W = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
  localparam int unsigned OA_W = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
  localparam int unsigned CI_W = $clog2(CRTC_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Architectural registers.
  logic [7:0]        crtc [CRTC_COUNT];
  logic [SEL_W-1:0]  sel, sel_next;
  logic [7:0]        mode, mode_next;
  logic [7:0]        color, color_next;
  logic [FRAME_W-1:0] frame, frame_next;
  logic [LINE_W-1:0] line, line_next;
  logic [BLINK_W-1:0] blink_cnt, blink_cnt_next;
  logic              blink, blink_next;
  logic              changed, changed_next;
  logic [EA_W-1:0]   clr_cnt;

  // Result register.
  logic              o_valid;
  logic              o_claimed;
  logic [DATA_W-1:0] o_rd;
  logic              o_blink, o_dirty;
  logic [7:0]        o_mode, o_color;
  logic              out_free;

  // Saved context of a video memory read.
  logic              sv_par, sv_last;
  logic [1:0]        sv_be;
  logic [EA_W-1:0]   sv_ea;
  logic [OA_W-1:0]   sv_oa;

  logic              sel_ok;
  logic [7:0]        crtc_q;
  logic [7:0]        status;
  logic [DATA_W-1:0] rd_now;
  logic              claimed_now;

  logic [EA_W-1:0]   hd_ea;
  logic [OA_W-1:0]   hd_oa;
  logic [EA_W-1:0]   ev_raddr, ev_waddr;
  logic [OA_W-1:0]   od_raddr, od_waddr;
  logic              ev_we, od_we;
  logic [7:0]        ev_wdata, od_wdata, ev_q, od_q;
  logic              lo_en, hi_en;
  logic [7:0]        lo_b;
  logic [DATA_W-1:0] vram_rd;

  assign clearing = (state == S_CLEAR);
  assign out_free = !o_valid || m_axis_tready;
  assign q_pop    = (state == S_RUN) && q_valid && out_free;

  // Even bytes live in one bank and odd bytes in the other, so a word at any
  // offset touches each bank once.
  assign hd_ea = EA_W'(q_head.off >> 1) + EA_W'(q_head.off[0] && !q_head.last);
  assign hd_oa = OA_W'(q_head.off >> 1);

  assign lo_en = !q_head.word || q_head.be[0];
  assign hi_en = q_head.word && q_head.be[1] && !q_head.last;
  assign lo_b  = q_head.word ? q_head.data[7:0] : q_head.wbyte;

  always_comb begin
    ev_raddr = (state == S_RUN) ? hd_ea : sv_ea;
    od_raddr = (state == S_RUN) ? hd_oa : sv_oa;
    if (state == S_CLEAR) begin
      ev_we    = 1'b1;
      od_we    = (32'(clr_cnt) < ODD_DEPTH);
      ev_waddr = clr_cnt;
      od_waddr = OA_W'(clr_cnt);
      ev_wdata = 8'h00;
      od_wdata = 8'h00;
    end else begin
      ev_we    = q_pop && (q_head.kind == K_VWR) && (q_head.off[0] ? hi_en : lo_en);
      od_we    = q_pop && (q_head.kind == K_VWR) && (q_head.off[0] ? lo_en : hi_en);
      ev_waddr = hd_ea;
      od_waddr = hd_oa;
      ev_wdata = q_head.off[0] ? q_head.data[15:8] : lo_b;
      od_wdata = q_head.off[0] ? lo_b : q_head.data[15:8];
    end
  end

  cga_ram #(.WIDTH(8), .DEPTH(EVEN_DEPTH)) u_even (
    .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
    .raddr(ev_raddr), .rdata(ev_q)
  );

  cga_ram #(.WIDTH(8), .DEPTH(ODD_DEPTH)) u_odd (
    .clk(clk), .we(od_we), .waddr(od_waddr), .wdata(od_wdata),
    .raddr(od_raddr), .rdata(od_q)
  );

  always_comb begin
    if (sv_be == BE_BOTH && !sv_last) begin
      vram_rd = sv_par ? {ev_q, od_q} : {od_q, ev_q};
    end else begin
      vram_rd = on_lane(sv_be, sv_par ? od_q : ev_q);
    end
  end

  assign sel_ok = (6'(sel) < 6'(CRTC_COUNT));
  assign crtc_q = sel_ok ? crtc[sel[CI_W-1:0]] : 8'h00;

  always_comb begin
    if (32'(frame) >= RETRACE_START)       status = STAT_RETRACE;
    else if (32'(line) < DISPLAY_TICKS)    status = STAT_DISPLAY;
    else                                   status = 8'h00;
  end

  always_comb begin
    case (q_head.kind)
      K_CRD:   rd_now = on_lane(q_head.be, crtc_q);
      K_STAT:  rd_now = on_lane(q_head.be, status);
      default: rd_now = '0;
    endcase
    claimed_now = (q_head.kind != K_NONE) && (q_head.kind != K_TICK);
  end

  // Next architectural state for the item at the head of the queue.
  always_comb begin
    sel_next       = sel;
    mode_next      = mode;
    color_next     = color;
    frame_next     = frame;
    line_next      = line;
    blink_cnt_next = blink_cnt;
    blink_next     = blink;
    changed_next   = changed;
    case (q_head.kind)
      K_TICK: begin
        if (18'(frame) + 18'd1 == 18'(FRAME_TICKS)) begin
          frame_next = '0;
          line_next  = '0;
        end else begin
          frame_next = frame + 1'b1;
          line_next  = (11'(line) + 11'd1 == 11'(LINE_TICKS)) ? '0 : line + 1'b1;
        end
        if (23'(blink_cnt) + 23'd1 >= 23'(BLINK_HALF_TICKS)) begin
          blink_cnt_next = '0;
          blink_next     = !blink;
          changed_next   = 1'b1;
        end else begin
          blink_cnt_next = blink_cnt + 1'b1;
        end
      end
      K_VWR:   changed_next = 1'b1;
      K_IDX:   sel_next     = q_head.wbyte[SEL_W-1:0];
      K_CWR:   changed_next = changed || sel_ok;
      K_MODE: begin
        mode_next    = q_head.wbyte;
        changed_next = 1'b1;
      end
      K_COLOR: begin
        color_next   = q_head.wbyte;
        changed_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == EA_W'(EVEN_DEPTH - 1)) state_next = S_RUN;
      S_RUN:   if (q_pop && q_head.kind == K_VRD) state_next = S_READ;
      S_READ:  if (out_free) state_next = S_RUN;
      default: state_next = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      sel       <= '0;
      mode      <= RST_MODE;
      color     <= 8'h00;
      frame     <= '0;
      line      <= '0;
      blink_cnt <= '0;
      blink     <= 1'b0;
      changed   <= 1'b1;
      o_valid   <= 1'b0;
      for (int i = 0; i < CRTC_COUNT; i++) begin
        crtc[i] <= crtc_init(SEL_W'(i));
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (q_pop) begin
        sel       <= sel_next;
        mode      <= mode_next;
        color     <= color_next;
        frame     <= frame_next;
        line      <= line_next;
        blink_cnt <= blink_cnt_next;
        blink     <= blink_next;
        changed   <= changed_next;
        if (q_head.kind == K_CWR && sel_ok) begin
          crtc[sel[CI_W-1:0]] <= q_head.wbyte & crtc_mask(sel);
        end
      end
      if (q_pop && q_head.kind != K_VRD) begin
        o_valid <= 1'b1;
      end else if (state == S_READ && out_free) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Result payload and saved read context need no reset.
  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == K_VRD) begin
      sv_par  <= q_head.off[0];
      sv_last <= q_head.last;
      sv_be   <= q_head.be;
      sv_ea   <= hd_ea;
      sv_oa   <= hd_oa;
    end
    if (q_pop && q_head.kind != K_VRD) begin
      o_claimed <= claimed_now;
      o_rd      <= rd_now;
      o_blink   <= blink_next;
      o_dirty   <= changed_next;
      o_mode    <= mode_next;
      o_color   <= color_next;
    end else if (state == S_READ && out_free) begin
      o_claimed <= 1'b1;
      o_rd      <= vram_rd;
      o_blink   <= blink;
      o_dirty   <= changed;
      o_mode    <= mode;
      o_color   <= color;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_claimed;
  assign m_axis_tdata  = {6'b0, o_color, o_mode, o_dirty, o_blink, o_rd};

endmodule
